/* rtl/icyd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icyd_pkg
// Shared types, codes and the title pattern for the ICY metadata deframer.
// ----------------------------------------------------------------------------
package icyd_pkg;

    // Width of the audio interval counter and of the configuration data
    localparam int INTERVAL_BITS = 24;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL = 2'd1;

    // Result kinds
    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_TITLE  = 2'd1;
    localparam logic [1:0] KIND_COMMIT = 2'd2;
    localparam logic [1:0] KIND_ABORT  = 2'd3;

    // Stream phase codes
    localparam logic PH_AUDIO = 1'b0;
    localparam logic PH_BLOCK = 1'b1;

    // Title matcher codes
    localparam logic [1:0] TP_SEARCH = 2'd0;
    localparam logic [1:0] TP_SKIP   = 2'd1;
    localparam logic [1:0] TP_COPY   = 2'd2;
    localparam logic [1:0] TP_DONE   = 2'd3;

    // Pattern "StreamTitle=" and special bytes
    localparam logic [3:0] PAT_LEN   = 4'd12;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       mute;
    } icyd_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
    } icyd_out_t;

    // Configuration write seen by the core
    typedef struct packed {
        logic                     valid;
        logic [CFG_IDX_W-1:0]     index;
        logic [INTERVAL_BITS-1:0] value;
    } icyd_cfg_wr_t;

    // Result of one byte, handed to the output register
    typedef struct packed {
        logic      valid;
        icyd_out_t payload;
    } icyd_res_t;

    // Byte of "StreamTitle=" at a given match position
    function automatic logic [7:0] pat_byte(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h53; // S
            4'd1:    c = 8'h74; // t
            4'd2:    c = 8'h72; // r
            4'd3:    c = 8'h65; // e
            4'd4:    c = 8'h61; // a
            4'd5:    c = 8'h6D; // m
            4'd6:    c = 8'h54; // T
            4'd7:    c = 8'h69; // i
            4'd8:    c = 8'h74; // t
            4'd9:    c = 8'h6C; // l
            4'd10:   c = 8'h65; // e
            4'd11:   c = 8'h3D; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/icyd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icyd_core
// Configuration registers, stream counters and title matcher. Works out the
// result of one byte combinationally; state advances on steps and cfg writes.
// ----------------------------------------------------------------------------
module icyd_core
    import icyd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire icyd_cfg_wr_t cfg_wr,
    input  wire logic         step,
    input  wire icyd_in_t     step_data,
    output icyd_res_t         res
);

    logic                     metadata_enable_reg, metadata_enable_next;
    logic [INTERVAL_BITS-1:0] meta_interval_reg, meta_interval_next;
    logic                     phase_reg, phase_next;
    logic [INTERVAL_BITS-1:0] audio_left_reg, audio_left_next;
    logic [11:0]              block_left_reg, block_left_next;
    logic [3:0]               match_pos_reg, match_pos_next;
    logic [1:0]               title_phase_reg, title_phase_next;
    logic [7:0]               held_byte_reg, held_byte_next;
    logic                     held_valid_reg, held_valid_next;

    logic [7:0]  b;
    logic [11:0] bl_dec;
    logic        meta_off;

    assign b        = step_data.data_byte;
    assign meta_off = !metadata_enable_reg || (meta_interval_reg == '0);
    assign bl_dec   = (block_left_reg != 12'd0) ? (block_left_reg - 12'd1) : 12'd0;

    // Work out next state and result
    always_comb
    begin
        metadata_enable_next = metadata_enable_reg;
        meta_interval_next   = meta_interval_reg;
        phase_next           = phase_reg;
        audio_left_next      = audio_left_reg;
        block_left_next      = block_left_reg;
        match_pos_next       = match_pos_reg;
        title_phase_next     = title_phase_reg;
        held_byte_next       = held_byte_reg;
        held_valid_next      = held_valid_reg;
        res                  = '0;

        if (cfg_wr.valid)
        begin
            if (cfg_wr.index == CFG_IDX_ENABLE)
            begin
                metadata_enable_next = cfg_wr.value[0];
            end
            else if (cfg_wr.index == CFG_IDX_INTERVAL)
            begin
                meta_interval_next = cfg_wr.value;
                audio_left_next    = cfg_wr.value;
                phase_next         = PH_AUDIO;
                block_left_next    = 12'd0;
                match_pos_next     = 4'd0;
                title_phase_next   = TP_SEARCH;
                held_byte_next     = 8'd0;
                held_valid_next    = 1'b0;
            end
        end
        else if (step)
        begin
            if (meta_off)
            begin
                // Pass everything as audio, state frozen
                res.valid            = !step_data.mute;
                res.payload.kind     = KIND_AUDIO;
                res.payload.out_byte = b;
            end
            else if (phase_reg == PH_AUDIO)
            begin
                if (audio_left_reg != '0)
                begin
                    audio_left_next      = audio_left_reg - INTERVAL_BITS'(1);
                    res.valid            = !step_data.mute;
                    res.payload.kind     = KIND_AUDIO;
                    res.payload.out_byte = b;
                end
                else
                begin
                    // Length byte: times 16, no result
                    block_left_next = {b, 4'b0000};
                    if (b == 8'd0)
                    begin
                        audio_left_next = meta_interval_reg;
                    end
                    else
                    begin
                        phase_next       = PH_BLOCK;
                        match_pos_next   = 4'd0;
                        title_phase_next = TP_SEARCH;
                        held_byte_next   = 8'd0;
                        held_valid_next  = 1'b0;
                    end
                end
            end
            else
            begin
                block_left_next = bl_dec;

                case (title_phase_reg)
                    TP_SEARCH:
                    begin
                        if ((match_pos_reg < PAT_LEN) && (b == pat_byte(match_pos_reg)))
                        begin
                            if (match_pos_reg == PAT_LEN - 4'd1)
                            begin
                                match_pos_next   = 4'd0;
                                title_phase_next = TP_SKIP;
                            end
                            else
                            begin
                                match_pos_next = match_pos_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            match_pos_next = (b == CHAR_S) ? 4'd1 : 4'd0;
                        end
                    end
                    TP_SKIP:
                    begin
                        title_phase_next = TP_COPY;
                        held_valid_next  = 1'b0;
                    end
                    TP_COPY:
                    begin
                        if (b == CHAR_SEMI)
                        begin
                            res.valid            = 1'b1;
                            res.payload.kind     = KIND_COMMIT;
                            res.payload.out_byte = 8'd0;
                            title_phase_next     = TP_DONE;
                            held_valid_next      = 1'b0;
                        end
                        else
                        begin
                            // Release the held byte, hold the new one
                            res.valid            = held_valid_reg;
                            res.payload.kind     = KIND_TITLE;
                            res.payload.out_byte = held_byte_reg;
                            held_byte_next       = b;
                            held_valid_next      = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // End of block: abort an open title, return to audio
                if (bl_dec == 12'd0)
                begin
                    if ((title_phase_next == TP_SKIP) || (title_phase_next == TP_COPY))
                    begin
                        res.valid            = 1'b1;
                        res.payload.kind     = KIND_ABORT;
                        res.payload.out_byte = 8'd0;
                    end
                    phase_next       = PH_AUDIO;
                    audio_left_next  = meta_interval_reg;
                    match_pos_next   = 4'd0;
                    title_phase_next = TP_SEARCH;
                    held_byte_next   = 8'd0;
                    held_valid_next  = 1'b0;
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metadata_enable_reg <= 1'b0;
            meta_interval_reg   <= '0;
            phase_reg           <= PH_AUDIO;
            audio_left_reg      <= '0;
            block_left_reg      <= 12'd0;
            match_pos_reg       <= 4'd0;
            title_phase_reg     <= TP_SEARCH;
            held_byte_reg       <= 8'd0;
            held_valid_reg      <= 1'b0;
        end
        else
        begin
            metadata_enable_reg <= metadata_enable_next;
            meta_interval_reg   <= meta_interval_next;
            phase_reg           <= phase_next;
            audio_left_reg      <= audio_left_next;
            block_left_reg      <= block_left_next;
            match_pos_reg       <= match_pos_next;
            title_phase_reg     <= title_phase_next;
            held_byte_reg       <= held_byte_next;
            held_valid_reg      <= held_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // The audio phase always runs with a cleared matcher
    a_audio_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_AUDIO) |-> (match_pos_reg == 4'd0) &&
            (title_phase_reg == TP_SEARCH) && !held_valid_reg)
        else $error("matcher not cleared in audio phase");

    // A block in progress always has bytes left
    a_block_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BLOCK) |-> (block_left_reg != 12'd0))
        else $error("block phase with zero bytes left");

    // A held byte exists only while copying the title
    a_held_copy: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (title_phase_reg == TP_COPY))
        else $error("held byte outside copy phase");
`endif

endmodule
`default_nettype wire

/* rtl/icyd_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icyd_out_reg
// Result register of the deframer. Loads a result on each step and holds it
// until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module icyd_out_reg
    import icyd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire icyd_res_t res,
    output logic           free,
    output logic           out_valid,
    input  wire logic      out_ready,
    output icyd_out_t      out_data
);

    logic      out_valid_reg, out_valid_next;
    icyd_out_t out_data_reg, out_data_next;

    // Register is free when empty or its beat leaves this cycle
    assign free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = res.valid;
            out_data_next  = res.payload;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance payload without reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* rtl/icy_metadata_deframer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icy_metadata_deframer_top
// Splits ICY stream body bytes into audio bytes and stream-title beats.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------
//   in      | input     | in_valid / in_ready  | in_data (data_byte, mute)
//   out     | output    | out_valid / out_ready| out_data (kind, out_byte)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle sustained while the output is ready; each byte passes
// the input register, then one pass of counter and matcher logic into the
// result register. Bytes that give no result leave no output beat.
// Reset clears all control state at once; no clearing pass is needed.
// A stalled output holds one result and one more byte in the input register.
// Configuration writes are always ready and apply on the next cycle.
// ----------------------------------------------------------------------------
module icy_metadata_deframer_top
    import icyd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire icyd_in_t                 in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output icyd_out_t                     out_data,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [INTERVAL_BITS-1:0] cfg_data
);

    logic         s1_valid_reg, s1_valid_next;
    icyd_in_t     s1_data_reg;
    logic         step;
    logic         free;
    icyd_res_t    res;
    icyd_cfg_wr_t cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = '{valid: cfg_valid, index: cfg_index, value: cfg_data};

    // Advance the input register into the result register
    assign step     = s1_valid_reg && free;
    assign in_ready = !s1_valid_reg || free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    icyd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .step      (step),
        .step_data (s1_data_reg),
        .res       (res)
    );

    icyd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // Input stalls only when both registers are full and the output is held
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid && !out_ready))
        else $error("input stalled without a full pipeline");

    // A held output beat stays valid and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output beat changed while stalled");

    // A waiting input byte stays in its register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !step) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("input register changed while waiting");
`endif

endmodule
`default_nettype wire

/* test/icy_metadata_deframer_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icy_metadata_deframer_top_tb
// Drives ICY stream body bytes into the deframer and checks every audio,
// title, commit and abort beat against a local deframing model. Directed
// frames cover the title corner cases; random frames with random settings,
// idle gaps, stalls and one long output hold-off cover the rest.
// ----------------------------------------------------------------------------
module icy_metadata_deframer_top_tb;
    import icyd_pkg::*;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    // Title key as a packed string, first character in the top byte
    localparam logic [8*12-1:0] TITLE_KEY = "StreamTitle=";

    typedef logic [7:0] byte_q_t[$];

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    icyd_in_t                 in_beat = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    icyd_out_t                out_beat;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_IDX_ENABLE;
    logic [INTERVAL_BITS-1:0] cfg_data = '0;

    // Deframer model state and settings
    logic                     meta_on = 1'b0;
    logic [INTERVAL_BITS-1:0] interval = '0;
    logic                     stream_ph = PH_AUDIO;
    logic [INTERVAL_BITS-1:0] audio_cnt = '0;
    logic [11:0]              block_cnt = '0;
    logic [3:0]               match_idx = '0;
    logic [1:0]               title_st = TP_SEARCH;
    logic [7:0]               held = '0;
    logic                     held_ok = 1'b0;

    icyd_out_t deframed_q[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        tx_mode = 1;
    int        rx_mode = 1;
    int        hold_asks = 0;
    int        idle_cycles = 0;

    icy_metadata_deframer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Wait cycles per beat: 0 never idles, 1 idles uniformly, 2 idles rarely
    function automatic int draw_wait(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 10);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
    endfunction

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        return TITLE_KEY[8*(11 - int'(pos)) +: 8];
    endfunction

    function automatic void clear_title();
        match_idx = '0;
        title_st  = TP_SEARCH;
        held      = '0;
        held_ok   = 1'b0;
    endfunction

    // Advance the model by one body byte and queue the beat it yields
    function automatic void deframe_byte(input logic [7:0] b, input logic m);
        logic       hit;
        logic [1:0] k;
        logic [7:0] v;
        hit = 1'b0;
        k   = KIND_AUDIO;
        v   = b;
        if (!meta_on || interval == '0)
        begin
            hit = !m;
        end
        else if (stream_ph == PH_AUDIO)
        begin
            if (audio_cnt != '0)
            begin
                audio_cnt = audio_cnt - INTERVAL_BITS'(1);
                hit = !m;
            end
            else
            begin
                // length byte: unsigned count of 16-byte units
                block_cnt = {b, 4'h0};
                if (block_cnt == '0)
                    audio_cnt = interval;
                else
                begin
                    stream_ph = PH_BLOCK;
                    clear_title();
                end
            end
        end
        else
        begin
            if (block_cnt != '0)
                block_cnt = block_cnt - 12'd1;
            case (title_st)
                TP_SEARCH:
                begin
                    if (match_idx < PAT_LEN && b == key_char(match_idx))
                    begin
                        match_idx = match_idx + 4'd1;
                        if (match_idx == PAT_LEN)
                        begin
                            match_idx = '0;
                            title_st  = TP_SKIP;
                        end
                    end
                    else
                        match_idx = (b == CHAR_S) ? 4'd1 : 4'd0;
                end
                TP_SKIP:
                begin
                    title_st = TP_COPY;
                    held_ok  = 1'b0;
                end
                TP_COPY:
                begin
                    if (b == CHAR_SEMI)
                    begin
                        hit      = 1'b1;
                        k        = KIND_COMMIT;
                        v        = 8'h00;
                        title_st = TP_DONE;
                        held_ok  = 1'b0;
                    end
                    else
                    begin
                        // hold one byte back so the closing quote drops
                        if (held_ok)
                        begin
                            hit = 1'b1;
                            k   = KIND_TITLE;
                            v   = held;
                        end
                        held    = b;
                        held_ok = 1'b1;
                    end
                end
                default: ;
            endcase
            if (block_cnt == '0)
            begin
                if (title_st == TP_SKIP || title_st == TP_COPY)
                begin
                    hit = 1'b1;
                    k   = KIND_ABORT;
                    v   = 8'h00;
                end
                stream_ph = PH_AUDIO;
                audio_cnt = interval;
                clear_title();
            end
        end
        if (hit)
            deframed_q.push_back('{kind: k, out_byte: v});
    endfunction

    // Send one body byte; valid stays up across back-to-back beats
    task automatic send_byte(input logic [7:0] b, input logic m);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{data_byte: b, mute: m};
        do @(posedge clk); while (!in_ready);
        deframe_byte(b, m);
        items_sent++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // Send a length byte and its block; the body is cut or padded to size
    task automatic send_block(input logic [7:0] len, input byte_q_t body);
        int total;
        total = int'(len) * 16;
        send_byte(len, 1'($urandom_range(0, 1)));
        for (int i = 0; i < total; i++)
            send_byte((i < body.size()) ? body[i] : 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic byte_q_t cat(input byte_q_t a, input byte_q_t b);
        foreach (b[i])
            a.push_back(b[i]);
        return a;
    endfunction

    function automatic byte_q_t rand_bytes(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    // Random title text that never holds a semicolon
    function automatic byte_q_t rand_title(input int n);
        byte_q_t    q;
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(0, 255));
            q.push_back((c == CHAR_SEMI) ? 8'h3A : c);
        end
        return q;
    endfunction

    // Well-formed title field with a random opening quote byte and random text
    function automatic byte_q_t title_field(input int n);
        byte_q_t q;
        q = text_bytes("StreamTitle=");
        q.push_back(8'($urandom_range(0, 255)));
        q = cat(q, rand_title(n));
        q.push_back(8'h27);
        q.push_back(CHAR_SEMI);
        return q;
    endfunction

    // Hold off until all beats are out and the pipeline has emptied
    task automatic drain_all();
        in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [INTERVAL_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_ENABLE)
            meta_on = val[0];
        else if (idx == CFG_IDX_INTERVAL)
        begin
            interval  = val;
            audio_cnt = val;
            stream_ph = PH_AUDIO;
            block_cnt = '0;
            clear_title();
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic check_beat(input icyd_out_t got);
        icyd_out_t want;
        if (deframed_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected beat, expected none, actual kind %0d byte %02h",
                     $time, got.kind, got.out_byte);
            return;
        end
        want = deframed_q.pop_front();
        if (got.kind !== want.kind)
        begin
            mismatches++;
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, got.kind);
        end
        if (got.out_byte !== want.out_byte)
        begin
            mismatches++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.out_byte, got.out_byte);
        end
    endtask

    // Receive side: check each beat, then stall for a drawn number of cycles
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_beat(out_beat);
                stall_left = draw_wait(rx_mode);
            end
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // End the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Metadata off: every byte is audio, mute drops it
    task automatic test_passthrough();
        tx_mode = 2;
        rx_mode = 2;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_all();
        write_reg(CFG_IDX_ENABLE, 24'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3B, 1'b0);
        drain_all();
        write_reg(CFG_IDX_ENABLE, 24'd0);
        write_reg(CFG_IDX_INTERVAL, 24'd3);
        send_random(6);
        drain_all();
    endtask

    // Title corner cases at a short interval
    task automatic test_title_cases();
        tx_mode = 1;
        rx_mode = 1;
        write_reg(CFG_IDX_ENABLE, 24'd1);
        write_reg(CFG_IDX_INTERVAL, 24'd3);
        send_random(3);
        send_block(8'd2, text_bytes("StreamTitle='Hi';"));
        send_random(3);
        send_byte(8'h00, 1'b0);
        send_random(3);
        send_block(8'd1, text_bytes("StreamTitle='';"));
        send_random(3);
        send_block(8'd1, text_bytes("StreamTitle='x;"));
        send_random(3);
        send_block(8'd1, text_bytes("StreamTitle=;x;"));
        send_random(3);
        send_block(8'd1, text_bytes("StreamTitle='abc"));
        send_random(3);
        send_block(8'd1, text_bytes("xxxxStreamTitle="));
        send_random(3);
        send_block(8'd3, text_bytes("SStreamTitle='A';StreamTitle='B';"));
        send_random(3);
        send_block(8'd1, text_bytes("no title in here"));
        drain_all();
    endtask

    // Reload from an interval write in the middle of the audio run
    task automatic test_interval_write();
        send_random(1);
        drain_all();
        write_reg(CFG_IDX_INTERVAL, 24'd2);
        send_random(2);
        send_block(8'd1, text_bytes("StreamTitle='Q';"));
        drain_all();
    endtask

    // Largest length byte and interval extremes
    task automatic test_extremes();
        byte_q_t body;
        tx_mode = 0;
        rx_mode = 0;
        write_reg(CFG_IDX_INTERVAL, 24'd1);
        send_random(1);
        // Open the largest block, run a title through part of it, then restart
        body = cat(rand_bytes(100), text_bytes("StreamTitle='Long one';"));
        send_byte(8'hFF, 1'b0);
        foreach (body[i])
            send_byte(body[i], 1'($urandom_range(0, 1)));
        drain_all();
        write_reg(CFG_IDX_INTERVAL, 24'd1);
        send_random(1);
        send_block(8'd1, cat(text_bytes("StreamTitle='"), rand_title(16)));
        drain_all();
        write_reg(CFG_IDX_INTERVAL, 24'hFFFFFF);
        send_random(20);
        drain_all();
    endtask

    // Hold the output off while bytes keep coming so the input stalls
    task automatic test_backpressure();
        tx_mode = 0;
        rx_mode = 0;
        write_reg(CFG_IDX_ENABLE, 24'd0);
        hold_asks++;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        drain_all();
    endtask

    // One random frame: mostly well formed, some broken, some raw noise
    task automatic random_frame();
        byte_q_t    body;
        logic [7:0] len;
        int         pick;
        pick = $urandom_range(0, 19);
        if (!meta_on || interval == '0 || pick == 0)
        begin
            send_random($urandom_range(1, 24));
            return;
        end
        if (stream_ph == PH_BLOCK)
            send_random(int'(block_cnt));
        send_random(int'(audio_cnt));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 8'd0;
        else if (pick == 1)
            len = 8'($urandom_range(4, 8));
        else
            len = 8'($urandom_range(1, 3));
        case ($urandom_range(0, 9))
            0: body = rand_bytes($urandom_range(0, 40));
            1: body = cat(text_bytes("StreamTitle="), rand_title(int'(len) * 16));
            2: body = cat(cat(rand_bytes($urandom_range(0, 3)), text_bytes("SStreamTi")),
                          title_field($urandom_range(0, 8)));
            3: body = cat(title_field($urandom_range(0, 4)),
                          title_field($urandom_range(0, 4)));
            default: body = cat(rand_bytes($urandom_range(0, 3)),
                                title_field($urandom_range(0, 10)));
        endcase
        send_block(len, body);
    endtask

    task automatic test_random_stream();
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            drain_all();
            pick = $urandom_range(0, 9);
            write_reg(CFG_IDX_ENABLE, (pick == 0) ? 24'd0 : 24'd1);
            if (pick == 1)
                write_reg(CFG_IDX_INTERVAL, 24'd0);
            else if (pick == 2)
                write_reg(CFG_IDX_INTERVAL, 24'd1);
            else
                write_reg(CFG_IDX_INTERVAL, 24'($urandom_range(1, 24)));
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            repeat ($urandom_range(3, 8)) random_frame();
        end
        drain_all();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_passthrough();
        test_title_cases();
        test_interval_write();
        test_extremes();
        test_backpressure();
        test_random_stream();
        drain_all();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
